### sv/dsv_pkg.sv
// Shared types and constants for the displaced sphere vertex generator.
// No dependencies.
package dsv_pkg;

    typedef enum logic [1:0] {
        REG_GRID_COLS   = 2'd0,
        REG_GRID_ROWS   = 2'd1,
        REG_BASE_RADIUS = 2'd2,
        REG_HEIGHT_GAIN = 2'd3
    } reg_idx_t;

    // Sine/cosine value, Q1.15
    typedef logic signed [15:0] q15_t;

    // Register stages from phase to sine/cosine
    localparam int TRIG_LAT = 11;

endpackage

### sv/dsv_div.sv
// Pipelined restoring divider, one quotient bit per stage; keeps the low
// QW quotient bits. Depends on nothing.
module dsv_div #(
    parameter int DW = 30,
    parameter int VW = 14,
    parameter int QW = 16
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [DW-1:0] num_i,
    input  logic [VW-1:0] den_i,
    output logic [QW-1:0] quo_o
);

    logic [DW-1:0] num_reg [DW];
    logic [VW-1:0] den_reg [DW];
    logic [VW-1:0] rem_reg [DW];
    logic [QW-1:0] quo_reg [DW];

    logic [DW-1:0] num_prv [DW];
    logic [VW-1:0] den_prv [DW];
    logic [VW-1:0] rem_prv [DW];
    logic [QW-1:0] quo_prv [DW];

    logic [DW-1:0] num_next [DW];
    logic [VW-1:0] rem_next [DW];
    logic [QW-1:0] quo_next [DW];

    always_comb begin
        num_prv[0] = num_i;
        den_prv[0] = den_i;
        rem_prv[0] = '0;
        quo_prv[0] = '0;
        for (int s = 1; s < DW; s++) begin
            num_prv[s] = num_reg[s-1];
            den_prv[s] = den_reg[s-1];
            rem_prv[s] = rem_reg[s-1];
            quo_prv[s] = quo_reg[s-1];
        end
    end

    always_comb begin
        logic [VW:0] rem_sh;
        logic        ge;
        for (int s = 0; s < DW; s++) begin
            rem_sh = {rem_prv[s], num_prv[s][DW-1]};
            ge = (rem_sh >= {1'b0, den_prv[s]});
            rem_next[s] = ge ? VW'(rem_sh - {1'b0, den_prv[s]}) : VW'(rem_sh);
            num_next[s] = num_prv[s] << 1;
            quo_next[s] = {quo_prv[s][QW-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < DW; s++) begin
                num_reg[s] <= num_next[s];
                den_reg[s] <= den_prv[s];
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
            end
        end
    end

    assign quo_o = quo_reg[DW-1];

endmodule

### sv/dsv_trig.sv
// Pipelined sine/cosine of a phase: octant fold, Q30 Taylor series with
// constant divides as reciprocal multiplies, Q1.15 result. Uses dsv_pkg.
module dsv_trig #(
    parameter int TRIG_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [TRIG_BITS-1:0] phase_i,
    output dsv_pkg::q15_t        sin_o,
    output dsv_pkg::q15_t        cos_o
);
    import dsv_pkg::*;

    localparam int RW = TRIG_BITS - 2;
    localparam int XS = RW + 34;
    localparam logic [RW-1:0] EIGHTH  = RW'(1) << (TRIG_BITS - 3);
    localparam logic [RW:0]   QUARTER = (RW+1)'(1) << RW;
    localparam logic [63:0]   TWO_PI_Q30 = 64'd6746518852;
    localparam logic [15:0]   C_HI = 16'(TWO_PI_Q30 >> 17);
    localparam logic [16:0]   C_LO = 17'(TWO_PI_Q30);
    localparam logic [30:0]   ONE_Q30 = 31'h4000_0000;

    // floor(v/k) == (v*RCP) >> SH exactly for any 30-bit v
    localparam int SH_42 = 36;
    localparam int SH_20 = 35;
    localparam int SH_6  = 33;
    localparam int SH_56 = 36;
    localparam int SH_30 = 35;
    localparam int SH_12 = 34;
    localparam logic [31:0] RCP_42 = 32'(((64'd1 << SH_42) + 64'd41) / 64'd42);
    localparam logic [31:0] RCP_20 = 32'(((64'd1 << SH_20) + 64'd19) / 64'd20);
    localparam logic [31:0] RCP_6  = 32'(((64'd1 << SH_6) + 64'd5) / 64'd6);
    localparam logic [31:0] RCP_56 = 32'(((64'd1 << SH_56) + 64'd55) / 64'd56);
    localparam logic [31:0] RCP_30 = 32'(((64'd1 << SH_30) + 64'd29) / 64'd30);
    localparam logic [31:0] RCP_12 = 32'(((64'd1 << SH_12) + 64'd11) / 64'd12);

    function automatic logic [29:0] rcp_mul(input logic [29:0] v, input logic [31:0] m,
                                            input int sh);
        logic [61:0] p;
        p = 62'(v) * 62'(m);
        return 30'(p >> sh);
    endfunction

    function automatic logic [29:0] horner(input logic [29:0] a, input logic [29:0] q);
        logic [60:0] p;
        p = 61'(a) * 61'(ONE_Q30 - 31'(q));
        return 30'(p >> 30);
    endfunction

    function automatic q15_t to_q15(input logic [30:0] v);
        logic [16:0] q;
        q = 17'((32'(v) + 32'h4000) >> 15);
        return (q > 17'd32767) ? 16'sd32767 : signed'(16'(q));
    endfunction

    // quadrant and fold flag travel stages 1..10
    logic [1:0]    quad_reg [1:10];
    logic          swap_reg [1:10];
    logic [RW-1:0] rf_reg;
    logic [RW+15:0] ph_reg;
    logic [RW+16:0] pl_reg;
    logic [29:0]   x_reg [3:9];
    logic [29:0]   x2_reg [4:9];
    logic [29:0]   qs5_reg, qc5_reg, ps6_reg, pc6_reg, qs7_reg, qc7_reg;
    logic [29:0]   ps8_reg, pc8_reg, qs9_reg, qc9_reg, sv10_reg, pc10_reg;
    q15_t          sin_reg, cos_reg;

    logic [RW-1:0] r_in;
    logic          swap_next;
    logic [RW-1:0] rf_next;
    logic [XS-1:0] xsum;
    logic [59:0]   xx;
    logic [30:0]   cv;
    q15_t          s_q, c_q, s_sel, c_sel, sin_next, cos_next;

    always_comb begin
        r_in = phase_i[RW-1:0];
        swap_next = (r_in > EIGHTH);
        rf_next = swap_next ? RW'(QUARTER - {1'b0, r_in}) : r_in;
        xsum = (XS'(ph_reg) << 17) + XS'(pl_reg) + (XS'(1) << (TRIG_BITS - 1));
        xx = 60'(x_reg[3]) * 60'(x_reg[3]);
        cv = ONE_Q30 - 31'(pc10_reg >> 1);
        s_q = to_q15({1'b0, sv10_reg});
        c_q = to_q15(cv);
        s_sel = swap_reg[10] ? c_q : s_q;
        c_sel = swap_reg[10] ? s_q : c_q;
        unique case (quad_reg[10])
            2'd0: begin
                sin_next = s_sel;
                cos_next = c_sel;
            end
            2'd1: begin
                sin_next = c_sel;
                cos_next = -s_sel;
            end
            2'd2: begin
                sin_next = -s_sel;
                cos_next = -c_sel;
            end
            default: begin
                sin_next = -c_sel;
                cos_next = s_sel;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quad_reg[1] <= phase_i[TRIG_BITS-1:TRIG_BITS-2];
            swap_reg[1] <= swap_next;
            for (int k = 2; k <= 10; k++) begin
                quad_reg[k] <= quad_reg[k-1];
                swap_reg[k] <= swap_reg[k-1];
            end
            rf_reg <= rf_next;
            // split the angle constant to keep each product narrow
            ph_reg <= (RW+16)'(rf_reg) * (RW+16)'(C_HI);
            pl_reg <= (RW+17)'(rf_reg) * (RW+17)'(C_LO);
            x_reg[3] <= 30'(xsum >> TRIG_BITS);
            for (int k = 4; k <= 9; k++) begin
                x_reg[k] <= x_reg[k-1];
            end
            x2_reg[4] <= 30'(xx >> 30);
            for (int k = 5; k <= 9; k++) begin
                x2_reg[k] <= x2_reg[k-1];
            end
            qs5_reg <= rcp_mul(x2_reg[4], RCP_42, SH_42);
            qc5_reg <= rcp_mul(x2_reg[4], RCP_56, SH_56);
            ps6_reg <= horner(x2_reg[5], qs5_reg);
            pc6_reg <= horner(x2_reg[5], qc5_reg);
            qs7_reg <= rcp_mul(ps6_reg, RCP_20, SH_20);
            qc7_reg <= rcp_mul(pc6_reg, RCP_30, SH_30);
            ps8_reg <= horner(x2_reg[7], qs7_reg);
            pc8_reg <= horner(x2_reg[7], qc7_reg);
            qs9_reg <= rcp_mul(ps8_reg, RCP_6, SH_6);
            qc9_reg <= rcp_mul(pc8_reg, RCP_12, SH_12);
            sv10_reg <= horner(x_reg[9], qs9_reg);
            pc10_reg <= horner(x2_reg[9], qc9_reg);
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_o = sin_reg;
    assign cos_o = cos_reg;

endmodule

### sv/displaced_sphere_vertices.sv
// Top level of the displaced sphere vertex generator: APB register file,
// grid-to-phase dividers, sine/cosine units and vertex scaling. Uses dsv_pkg,
// dsv_div and dsv_trig.
//
// Usage: program grid_cols, grid_rows, base_radius and height_gain over the
// APB port while the pipeline is empty. Stream height samples with their
// column and row on the s_ channel; each transfer yields one vertex on the
// m_ channel, in order, with last_vertex copied from end_of_grid.
// Throughput is one vertex per cycle while the receiver does not stall the
// output. From an accepted transfer to m_valid a vertex passes one input
// stage, TRIG_BITS + 14 divider stages (one quotient bit each), eleven
// sine/cosine stages and three scaling stages ending in the output register.
// When the receiver holds m_ready low with a vertex waiting, the whole
// pipeline freezes and s_ready drops; nothing is dropped or repeated.
// Reset restores the default registers (64 x 32 grid, radius 256, zero
// gain) and empties the pipeline.
module displaced_sphere_vertices #(
    parameter int MAX_COLS  = 4096,
    parameter int MAX_ROWS  = 4096,
    parameter int TRIG_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [11:0]        s_col_index,
    input  logic [11:0]        s_row_index,
    input  logic [7:0]         s_height,
    input  logic               s_end_of_grid,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [24:0] m_pos_x,
    output logic signed [24:0] m_pos_y,
    output logic signed [24:0] m_pos_z,
    output logic               m_last_vertex
);
    import dsv_pkg::*;

    localparam int MAX_DIM = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
    localparam int VW  = $clog2(2 * MAX_DIM + 1);
    localparam int DW  = 12 + TRIG_BITS + 2;
    localparam int DLY = DW + TRIG_LAT;
    localparam logic [TRIG_BITS-1:0] QUARTER_PH = TRIG_BITS'(1) << (TRIG_BITS - 2);

    // configuration
    logic [12:0]        grid_cols_reg, grid_rows_reg;
    logic [15:0]        base_radius_reg;
    logic signed [15:0] height_gain_reg;
    reg_idx_t           reg_idx;
    logic               wr_en;

    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_cols_reg   <= 13'd64;
            grid_rows_reg   <= 13'd32;
            base_radius_reg <= 16'd256;
            height_gain_reg <= 16'sd0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_GRID_COLS:   grid_cols_reg   <= pwdata[12:0];
                REG_GRID_ROWS:   grid_rows_reg   <= pwdata[12:0];
                REG_BASE_RADIUS: base_radius_reg <= pwdata[15:0];
                REG_HEIGHT_GAIN: height_gain_reg <= signed'(pwdata[15:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_GRID_COLS:   prdata = 32'(grid_cols_reg);
            REG_GRID_ROWS:   prdata = 32'(grid_rows_reg);
            REG_BASE_RADIUS: prdata = 32'(base_radius_reg);
            REG_HEIGHT_GAIN: prdata = 32'(unsigned'(height_gain_reg));
            default:         prdata = '0;
        endcase
    end

    // pipeline advance: hold everything while a vertex waits at the output
    logic adv;
    logic m_valid_reg;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // input stage
    logic        a_valid_reg;
    logic [11:0] a_col_reg, a_row_reg;
    logic [7:0]  a_height_reg;
    logic        a_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_col_reg    <= s_col_index;
            a_row_reg    <= s_row_index;
            a_height_reg <= s_height;
            a_last_reg   <= s_end_of_grid;
        end
    end

    // grid clamps, divider operands and radius
    logic [31:0]        cols_c, rows_c, d_c;
    logic [DW-1:0]      lon_num, lat_num;
    logic [VW-1:0]      lon_den, lat_den;
    logic signed [24:0] base_s, hgt_s, gain_s, r_c;

    always_comb begin
        priority if (grid_cols_reg == 13'd0) begin
            cols_c = 32'd1;
        end else if (32'(grid_cols_reg) > 32'(MAX_COLS)) begin
            cols_c = 32'(MAX_COLS);
        end else begin
            cols_c = 32'(grid_cols_reg);
        end
        priority if (grid_rows_reg < 13'd2) begin
            rows_c = 32'd2;
        end else if (32'(grid_rows_reg) > 32'(MAX_ROWS)) begin
            rows_c = 32'(MAX_ROWS);
        end else begin
            rows_c = 32'(grid_rows_reg);
        end
        d_c = rows_c - 32'd1;
        // round half up: (2*col*2^T + cols) / (2*cols)
        lon_num = (DW'(a_col_reg) << (TRIG_BITS + 1)) + DW'(cols_c);
        lon_den = VW'(cols_c << 1);
        lat_num = (DW'(a_row_reg) << TRIG_BITS) + DW'(d_c);
        lat_den = VW'(d_c << 1);
        base_s = signed'(25'(base_radius_reg));
        hgt_s  = signed'(25'(a_height_reg));
        gain_s = 25'(height_gain_reg);
        r_c    = base_s + hgt_s * gain_s;
    end

    logic [TRIG_BITS-1:0] lon_q, lat_q, lon_ph, lat_ph;

    dsv_div #(.DW(DW), .VW(VW), .QW(TRIG_BITS)) u_div_lon (
        .aclk (aclk),
        .en   (adv),
        .num_i(lon_num),
        .den_i(lon_den),
        .quo_o(lon_q)
    );

    dsv_div #(.DW(DW), .VW(VW), .QW(TRIG_BITS)) u_div_lat (
        .aclk (aclk),
        .en   (adv),
        .num_i(lat_num),
        .den_i(lat_den),
        .quo_o(lat_q)
    );

    assign lon_ph = lon_q - QUARTER_PH;
    assign lat_ph = lat_q - QUARTER_PH;

    q15_t slon, clon, slat, clat;

    dsv_trig #(.TRIG_BITS(TRIG_BITS)) u_trig_lon (
        .aclk   (aclk),
        .en     (adv),
        .phase_i(lon_ph),
        .sin_o  (slon),
        .cos_o  (clon)
    );

    dsv_trig #(.TRIG_BITS(TRIG_BITS)) u_trig_lat (
        .aclk   (aclk),
        .en     (adv),
        .phase_i(lat_ph),
        .sin_o  (slat),
        .cos_o  (clat)
    );

    // sideband delay alongside dividers and trig units
    logic               dly_valid_reg [DLY];
    logic               dly_last_reg  [DLY];
    logic signed [24:0] dly_r_reg     [DLY];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DLY; k++) begin
                dly_valid_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            dly_valid_reg[0] <= a_valid_reg;
            for (int k = 1; k < DLY; k++) begin
                dly_valid_reg[k] <= dly_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dly_last_reg[0] <= a_last_reg;
            dly_r_reg[0]    <= r_c;
            for (int k = 1; k < DLY; k++) begin
                dly_last_reg[k] <= dly_last_reg[k-1];
                dly_r_reg[k]    <= dly_r_reg[k-1];
            end
        end
    end

    // scaling stages
    logic               f1_valid_reg, f1_last_reg;
    logic signed [40:0] f1_xprod_reg, f1_yprod_reg;
    q15_t               f1_slon_reg, f1_clon_reg;
    logic               f2_valid_reg, f2_last_reg;
    logic signed [56:0] f2_px_reg, f2_pz_reg;
    logic signed [24:0] f2_y_reg;
    logic signed [24:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic               last_reg;

    logic signed [40:0] y_rnd;
    logic signed [56:0] x_rnd, z_rnd;

    always_comb begin
        y_rnd = f1_yprod_reg + (41'sd1 <<< 14);
        x_rnd = -f2_px_reg + (57'sd1 <<< 29);
        z_rnd = f2_pz_reg + (57'sd1 <<< 29);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            f1_valid_reg <= dly_valid_reg[DLY-1];
            f2_valid_reg <= f1_valid_reg;
            m_valid_reg  <= f2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f1_last_reg  <= dly_last_reg[DLY-1];
            f1_xprod_reg <= 41'(dly_r_reg[DLY-1]) * 41'(clat);
            f1_yprod_reg <= 41'(dly_r_reg[DLY-1]) * 41'(slat);
            f1_slon_reg  <= slon;
            f1_clon_reg  <= clon;
            f2_last_reg  <= f1_last_reg;
            f2_px_reg    <= 57'(f1_xprod_reg) * 57'(f1_clon_reg);
            f2_pz_reg    <= 57'(f1_xprod_reg) * 57'(f1_slon_reg);
            f2_y_reg     <= 25'(y_rnd >>> 15);
            last_reg     <= f2_last_reg;
            pos_x_reg    <= 25'(x_rnd >>> 30);
            pos_y_reg    <= f2_y_reg;
            pos_z_reg    <= 25'(z_rnd >>> 30);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pos_x       = pos_x_reg;
    assign m_pos_y       = pos_y_reg;
    assign m_pos_z       = pos_z_reg;
    assign m_last_vertex = last_reg;

endmodule

### tb/sv/displaced_sphere_vertices_tb.sv
// Self-checking testbench for displaced_sphere_vertices: random grid samples,
// APB register setup and a bit-exact vertex predictor. Uses dsv_pkg.
module displaced_sphere_vertices_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dsv_pkg::*;

    localparam int PHASE_BITS = 16;
    localparam longint TWO_PI_Q30 = 64'd6746518852;
    localparam longint ONE_Q30 = 64'd1 << 30;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        logic signed [24:0] x;
        logic signed [24:0] y;
        logic signed [24:0] z;
        logic               last;
    } vertex_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [11:0] s_col_index = '0, s_row_index = '0;
    logic [7:0] s_height = '0;
    logic s_end_of_grid = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [24:0] m_pos_x, m_pos_y, m_pos_z;
    logic m_last_vertex;

    int error_count = 0;
    int idle_cycles = 0;
    bit stall_enable = 1'b1;

    always #2 aclk = ~aclk;

    displaced_sphere_vertices uut (.*);

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    class vertex_scoreboard;
        int unsigned cols = 64, rows = 32, radius = 256;
        logic signed [15:0] gain = 0;
        vertex_t pending[$];

        function automatic longint round_shift(longint v, int sh);
            return (v + (longint'(1) << (sh - 1))) >>> sh;
        endfunction

        function automatic longint to_q15(longint v);
            longint q;
            q = (v + (longint'(1) << 14)) >> 15;
            return q > 32767 ? 32767 : q;
        endfunction

        function automatic void sine_cosine(longint phase, output longint so, output longint co);
            longint p, quad, r, x, x2, t, sv, cv, s, c;
            bit swap;
            p = phase & ((1 << PHASE_BITS) - 1);
            quad = (p >> (PHASE_BITS - 2)) & 3;
            r = p & ((1 << (PHASE_BITS - 2)) - 1);
            swap = r > (1 << (PHASE_BITS - 3));
            if (swap) r = (1 << (PHASE_BITS - 2)) - r;
            x = (r * TWO_PI_Q30 + (1 << (PHASE_BITS - 1))) >> PHASE_BITS;
            x2 = (x * x) >> 30;
            t = ONE_Q30 - x2 / 42;
            t = ONE_Q30 - ((x2 * t) >> 30) / 20;
            t = ONE_Q30 - ((x2 * t) >> 30) / 6;
            sv = (x * t) >> 30;
            t = ONE_Q30 - x2 / 56;
            t = ONE_Q30 - ((x2 * t) >> 30) / 30;
            t = ONE_Q30 - ((x2 * t) >> 30) / 12;
            cv = ONE_Q30 - ((x2 * t) >> 30) / 2;
            s = to_q15(swap ? cv : sv);
            c = to_q15(swap ? sv : cv);
            case (quad)
                0: begin so = s; co = c; end
                1: begin so = c; co = -s; end
                2: begin so = -s; co = -c; end
                default: begin so = -c; co = s; end
            endcase
        endfunction

        function automatic void set_register(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_GRID_COLS:   cols = value[12:0];
                REG_GRID_ROWS:   rows = value[12:0];
                REG_BASE_RADIUS: radius = value[15:0];
                REG_HEIGHT_GAIN: gain = value[15:0];
            endcase
        endfunction

        function automatic void note_sample(logic [11:0] col, logic [11:0] row,
                                            logic [7:0] h, logic eog);
            longint c, rw, d, plon, plat, slon, clon, slat, clat, r, big;
            vertex_t v;
            c = cols < 1 ? 1 : (cols > 4096 ? 4096 : cols);
            rw = rows < 2 ? 2 : (rows > 4096 ? 4096 : rows);
            d = rw - 1;
            plon = ((longint'(col) << (PHASE_BITS + 1)) + c) / (2 * c);
            plon = (plon - (1 << (PHASE_BITS - 2))) & ((1 << PHASE_BITS) - 1);
            plat = ((longint'(row) << PHASE_BITS) + d) / (2 * d);
            plat = (plat - (1 << (PHASE_BITS - 2))) & ((1 << PHASE_BITS) - 1);
            sine_cosine(plon, slon, clon);
            sine_cosine(plat, slat, clat);
            r = longint'(radius) + longint'(h) * longint'(gain);
            big = -(r * clat * clon);
            v.x = 25'(round_shift(big, 30));
            v.y = 25'(round_shift(r * slat, 15));
            v.z = 25'(round_shift(r * clat * slon, 30));
            v.last = eog;
            pending.push_back(v);
        endfunction

        task automatic check_vertex(vertex_t got);
            vertex_t want;
            if (pending.size() == 0) begin
                report("unexpected vertex", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.x !== want.x) report("pos_x", got.x, want.x);
            if (got.y !== want.y) report("pos_y", got.y, want.y);
            if (got.z !== want.z) report("pos_z", got.z, want.z);
            if (got.last !== want.last) report("last_vertex", got.last, want.last);
        endtask
    endclass

    vertex_scoreboard vertices = new();

    // Monitor both channels and the watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                vertices.note_sample(s_col_index, s_row_index, s_height, s_end_of_grid);
            if (m_valid && m_ready)
                vertices.check_vertex('{m_pos_x, m_pos_y, m_pos_z, m_last_vertex});
            if ((s_valid && s_ready) || (m_valid && m_ready) || psel) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired");
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver stall pattern: runs of ready and not-ready of random length
    initial begin
        int run;
        forever begin
            run = $urandom_range(1, 20);
            repeat (run) begin
                @(posedge aclk);
                m_ready <= 1'b1;
            end
            if (stall_enable) begin
                run = $urandom_range(0, 6);
                repeat (run) begin
                    @(posedge aclk);
                    m_ready <= 1'b0;
                end
            end
        end
    end

    task automatic write_register(reg_idx_t idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 4'(idx) << 2; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        vertices.set_register(idx, value);
    endtask

    task automatic configure(int cols, int rows, int radius, int gain);
        write_register(REG_GRID_COLS, cols);
        write_register(REG_GRID_ROWS, rows);
        write_register(REG_BASE_RADIUS, radius);
        write_register(REG_HEIGHT_GAIN, gain);
    endtask

    // Present one sample and hold it until the transfer; valid stays high
    task automatic send_sample(logic [11:0] col, logic [11:0] row, logic [7:0] h, logic eog);
        s_valid <= 1'b1;
        s_col_index <= col; s_row_index <= row; s_height <= h; s_end_of_grid <= eog;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drop_valid(int gap);
        s_valid <= 1'b0;
        repeat (gap) @(posedge aclk);
    endtask

    task automatic drain();
        drop_valid(0);
        while (vertices.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_random_grid(int count, int cols, int rows);
        int burst;
        burst = $urandom_range(1, 30);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 7) == 0)
                send_sample(12'($urandom), 12'($urandom), 8'($urandom), 1'($urandom));
            else
                send_sample(12'($urandom_range(0, cols - 1)),
                            12'($urandom_range(0, rows - 1)),
                            8'($urandom), i == count - 1);
            burst--;
            if (burst == 0) begin
                drop_valid($urandom_range(1, 8));
                burst = $urandom_range(1, 30);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Defaults from reset, then extremes of every field
        send_sample(0, 0, 0, 0);
        send_sample(63, 31, 255, 1);
        drain();
        configure(4096, 4096, 65535, 16'sh7FFF);
        send_sample(0, 0, 255, 0);
        send_sample(4095, 4095, 255, 1);
        send_sample(2048, 2048, 128, 0);
        send_sample(1024, 4095, 1, 0);
        drain();
        configure(0, 1, 0, 16'sh8000);
        send_sample(0, 1, 255, 0);
        send_sample(4095, 0, 255, 1);
        send_sample(12'hAAA, 12'h555, 8'hAA, 0);
        send_sample(12'h555, 12'hAAA, 8'h55, 1);
        drain();
        configure(8191, 8191, 1000, 16'shFFFF);
        send_sample(4095, 4095, 255, 1);
        send_sample(5, 4000, 7, 0);
        drain();
        configure(3, 2, 65535, 0);
        send_sample(0, 0, 0, 0);
        send_sample(1, 1, 9, 0);
        send_sample(2, 2, 200, 1);
        drain();

        // Random phases over several grid setups
        for (int phase = 0; phase < 8; phase++) begin
            int cols, rows;
            cols = phase % 3 == 0 ? $urandom_range(1, 16) : $urandom_range(1, 4096);
            rows = phase % 3 == 1 ? $urandom_range(2, 16) : $urandom_range(2, 4096);
            configure(cols, rows, $urandom_range(0, 65535), $urandom_range(0, 65535));
            stall_enable = phase != 5;
            send_random_grid(110, cols, rows);
            // Hold off until every vertex is back, then continue the same grid
            drop_valid(0);
            while (vertices.pending.size() != 0) @(posedge aclk);
            send_random_grid(110, cols, rows);
            drain();
        end

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
